@@ src/touch_point_filter_and_scale_defines.svh @@
// Assertion macros shared by the checker files of the touch point filter.
// Needs nothing else; each macro expands to one labeled concurrent assertion.
`ifndef TOUCH_POINT_FILTER_AND_SCALE_DEFINES_SVH
`define TOUCH_POINT_FILTER_AND_SCALE_DEFINES_SVH

// Same-cycle implication, disabled while reset is held
`define TPFS_ASSERT_SAME(lbl, clk_s, rstn_s, ante, cons, msg) \
  lbl: assert property (@(posedge clk_s) disable iff (!rstn_s) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is held
`define TPFS_ASSERT_NEXT(lbl, clk_s, rstn_s, ante, cons, msg) \
  lbl: assert property (@(posedge clk_s) disable iff (!rstn_s) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ src/tpfs_pkg.sv @@
// Shared widths, reset values, register codes and control types of the
// touch point filter and scaler. No dependencies.
`default_nettype none

package tpfs_pkg;

  // Field widths
  localparam int WORD_W     = 16;
  localparam int RAW_W      = 12;
  localparam int SUM_W      = 15;
  localparam int ROT_W      = 2;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 12;

  localparam logic [RAW_W-1:0] RAW_MAX = 12'd4095;

  // Register reset values
  localparam logic [ROT_W-1:0] ROTATION_RST = 2'd0;
  localparam logic [RAW_W-1:0] WIDTH_RST    = 12'd320;
  localparam logic [RAW_W-1:0] HEIGHT_RST   = 12'd240;
  localparam logic [RAW_W-1:0] X_MIN_RST    = 12'd240;
  localparam logic [RAW_W-1:0] X_MAX_RST    = 12'd3900;
  localparam logic [RAW_W-1:0] Y_MIN_RST    = 12'd210;
  localparam logic [RAW_W-1:0] Y_MAX_RST    = 12'd3830;

  // Configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_ROTATION      = 3'd0,
    REG_SCREEN_WIDTH  = 3'd1,
    REG_SCREEN_HEIGHT = 3'd2,
    REG_X_CAL_MIN     = 3'd3,
    REG_X_CAL_MAX     = 3'd4,
    REG_Y_CAL_MIN     = 3'd5,
    REG_Y_CAL_MAX     = 3'd6
  } cfg_reg_t;

  // Screen orientation codes
  typedef enum logic [ROT_W-1:0] {
    ROT_FLIP_BOTH   = 2'd0,
    ROT_SWAP_FLIP_X = 2'd1,
    ROT_NONE        = 2'd2,
    ROT_SWAP_FLIP_Y = 2'd3
  } rot_t;

  // Sample strobe from the sequencer to an axis accumulator
  typedef struct packed {
    logic valid;   // a sample beat is taken this cycle
    logic first;   // it opens a new set
    logic last;    // it closes the set; start the mean
  } tm_ctl_t;

endpackage

`default_nettype wire

@@ src/tpfs_ifs.sv @@
// Handshake channels of the touch point filter: ADC pairs, results and
// register writes. Depends on tpfs_pkg.
`default_nettype none

interface tpfs_in_if;
  import tpfs_pkg::*;
  logic              valid;
  logic              ready;
  logic [WORD_W-1:0] x_word;
  logic [WORD_W-1:0] y_word;
  modport source (output valid, output x_word, output y_word, input ready);
  modport sink   (input valid, input x_word, input y_word, output ready);
endinterface

interface tpfs_out_if;
  import tpfs_pkg::*;
  logic             valid;
  logic             ready;
  logic             touched;
  logic [RAW_W-1:0] pixel_x;
  logic [RAW_W-1:0] pixel_y;
  modport source (output valid, output touched, output pixel_x, output pixel_y,
                  input ready);
  modport sink   (input valid, input touched, input pixel_x, input pixel_y,
                  output ready);
endinterface

interface tpfs_cfg_if;
  import tpfs_pkg::*;
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;
  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

@@ src/tpfs_trim_mean.sv @@
// One axis: tracks sum, minimum and maximum of a sample set, then forms
// (sum - max - min) / (SAMPLE_COUNT - 2) one quotient bit per cycle. Uses tpfs_pkg.
`default_nettype none

module tpfs_trim_mean #(
  parameter int SAMPLE_COUNT = 5
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  tpfs_pkg::tm_ctl_t          ctl,
  input  logic [tpfs_pkg::RAW_W-1:0] sample,
  output logic [tpfs_pkg::RAW_W-1:0] mean,
  output logic                       done
);
  import tpfs_pkg::*;

  localparam int DIVISOR = SAMPLE_COUNT - 2;
  localparam int REM_W   = $clog2(DIVISOR + 1);
  localparam int STEP_W  = $clog2(SUM_W);
  localparam logic [REM_W:0]    DIV_K     = (REM_W + 1)'(DIVISOR);
  localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(SUM_W - 1);

  typedef enum logic [3:0] {
    TM_ACC  = 4'b0001,
    TM_PREP = 4'b0010,
    TM_DIV  = 4'b0100,
    TM_DONE = 4'b1000
  } tm_state_t;

  tm_state_t         state_r, state_nxt;
  logic [STEP_W-1:0] step_r, step_nxt;

  logic [SUM_W-1:0] sum_r;
  logic [RAW_W-1:0] least_r;
  logic [RAW_W-1:0] greatest_r;
  logic [SUM_W-1:0] quo_r;
  logic [REM_W-1:0] rem_r;

  logic [SUM_W-1:0] sample_ext;
  logic [REM_W:0]   rem_sh;
  logic [REM_W:0]   rem_dif;
  logic             rem_ge;

  assign sample_ext = {{(SUM_W - RAW_W){1'b0}}, sample};

  // Restoring division step: bring down the next dividend bit
  assign rem_sh  = {rem_r, quo_r[SUM_W-1]};
  assign rem_ge  = rem_sh >= DIV_K;
  assign rem_dif = rem_sh - DIV_K;

  // Sequence the set, the setup and the serial divide
  always_comb begin
    state_nxt = state_r;
    step_nxt  = step_r;
    case (state_r)
      TM_ACC: begin
        if (ctl.valid && ctl.last) begin
          state_nxt = TM_PREP;
        end
      end
      TM_PREP: begin
        state_nxt = TM_DIV;
        step_nxt  = '0;
      end
      TM_DIV: begin
        if (step_r == LAST_STEP) begin
          state_nxt = TM_DONE;
        end else begin
          step_nxt = step_r + STEP_W'(1);
        end
      end
      TM_DONE: begin
        state_nxt = TM_ACC;
      end
      default: begin
        state_nxt = TM_ACC;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= TM_ACC;
      step_r  <= '0;
    end else begin
      state_r <= state_nxt;
      step_r  <= step_nxt;
    end
  end

  // Accumulate sum and extremes; the first beat of a set overwrites them
  always_ff @(posedge clk) begin
    if (ctl.valid) begin
      if (ctl.first) begin
        sum_r      <= sample_ext;
        least_r    <= sample;
        greatest_r <= sample;
      end else begin
        sum_r <= sum_r + sample_ext;
        if (sample < least_r) begin
          least_r <= sample;
        end
        if (sample > greatest_r) begin
          greatest_r <= sample;
        end
      end
    end
  end

  // Load the trimmed sum, then shift quotient bits in from the right
  always_ff @(posedge clk) begin
    case (state_r)
      TM_PREP: begin
        quo_r <= sum_r - {{(SUM_W - RAW_W){1'b0}}, greatest_r}
                       - {{(SUM_W - RAW_W){1'b0}}, least_r};
        rem_r <= '0;
      end
      TM_DIV: begin
        quo_r <= {quo_r[SUM_W-2:0], rem_ge};
        rem_r <= rem_ge ? rem_dif[REM_W-1:0] : rem_sh[REM_W-1:0];
      end
      default: begin
        quo_r <= quo_r;
        rem_r <= rem_r;
      end
    endcase
  end

  assign mean = quo_r[RAW_W-1:0];
  assign done = (state_r == TM_DONE);

endmodule

`default_nettype wire

@@ src/tpfs_axis_scale.sv @@
// One axis: scales a raw coordinate to pixels as size*(raw-lo)/(hi-lo) with a
// shift-add multiplier and a restoring divider, one bit per cycle. Uses tpfs_pkg.
`default_nettype none

module tpfs_axis_scale (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       start,
  input  logic [tpfs_pkg::RAW_W-1:0] raw,
  input  logic [tpfs_pkg::RAW_W-1:0] size,
  input  logic [tpfs_pkg::RAW_W-1:0] cal_lo,
  input  logic [tpfs_pkg::RAW_W-1:0] cal_hi,
  output logic [tpfs_pkg::RAW_W-1:0] pixel,
  output logic                       done
);
  import tpfs_pkg::*;

  localparam int PROD_W    = 2 * RAW_W;
  localparam int MUL_STEPS = RAW_W;
  localparam int DIV_STEPS = PROD_W;
  localparam int CNT_W     = $clog2(DIV_STEPS);
  localparam logic [CNT_W-1:0] MUL_LAST = CNT_W'(MUL_STEPS - 1);
  localparam logic [CNT_W-1:0] DIV_LAST = CNT_W'(DIV_STEPS - 1);

  typedef enum logic [4:0] {
    SC_IDLE = 5'b00001,
    SC_PREP = 5'b00010,
    SC_MUL  = 5'b00100,
    SC_DIV  = 5'b01000,
    SC_DONE = 5'b10000
  } sc_state_t;

  sc_state_t        state_r, state_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;

  logic [RAW_W-1:0]  raw_r;
  logic [RAW_W-1:0]  mag_d_r;
  logic              kill_r;
  logic [PROD_W-1:0] prod_r;
  logic [RAW_W-1:0]  rem_r;

  logic [RAW_W-1:0] mag_n;
  logic [RAW_W-1:0] mag_d;
  logic             raw_below;
  logic             hi_below;
  logic [RAW_W:0]   mul_sum;
  logic [RAW_W:0]   rem_sh;
  logic [RAW_W:0]   rem_dif;
  logic             rem_ge;

  // Magnitudes and signs of numerator and span
  assign raw_below = raw_r < cal_lo;
  assign hi_below  = cal_hi < cal_lo;
  assign mag_n     = raw_below ? (cal_lo - raw_r) : (raw_r - cal_lo);
  assign mag_d     = hi_below ? (cal_lo - cal_hi) : (cal_hi - cal_lo);

  // Multiply step: add size on a set multiplier bit, then shift right
  assign mul_sum = {1'b0, prod_r[PROD_W-1:RAW_W]} + (prod_r[0] ? {1'b0, size} : '0);

  // Divide step: bring down the next dividend bit, subtract when it fits
  assign rem_sh  = {rem_r, prod_r[PROD_W-1]};
  assign rem_ge  = rem_sh >= {1'b0, mag_d_r};
  assign rem_dif = rem_sh - {1'b0, mag_d_r};

  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    case (state_r)
      SC_IDLE, SC_DONE: begin
        if (start) begin
          state_nxt = SC_PREP;
        end
      end
      SC_PREP: begin
        state_nxt = SC_MUL;
        cnt_nxt   = '0;
      end
      SC_MUL: begin
        if (cnt_r == MUL_LAST) begin
          state_nxt = SC_DIV;
          cnt_nxt   = '0;
        end else begin
          cnt_nxt = cnt_r + CNT_W'(1);
        end
      end
      SC_DIV: begin
        if (cnt_r == DIV_LAST) begin
          state_nxt = SC_DONE;
        end else begin
          cnt_nxt = cnt_r + CNT_W'(1);
        end
      end
      default: begin
        state_nxt = SC_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= SC_IDLE;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

  // Datapath shift registers
  always_ff @(posedge clk) begin
    if (start) begin
      raw_r <= raw;
    end
    case (state_r)
      SC_PREP: begin
        prod_r  <= {{RAW_W{1'b0}}, mag_n};
        mag_d_r <= mag_d;
        kill_r  <= (cal_hi == cal_lo) || (raw_below != hi_below);
        rem_r   <= '0;
      end
      SC_MUL: begin
        prod_r <= {mul_sum, prod_r[RAW_W-1:1]};
      end
      SC_DIV: begin
        prod_r <= {prod_r[PROD_W-2:0], rem_ge};
        rem_r  <= rem_ge ? rem_dif[RAW_W-1:0] : rem_sh[RAW_W-1:0];
      end
      default: begin
        prod_r <= prod_r;
      end
    endcase
  end

  // Drop a negative, undefined or out-of-range quotient to zero
  assign pixel = (kill_r || (prod_r[PROD_W-1:RAW_W] != '0) || (prod_r[RAW_W-1:0] > size))
               ? '0 : prod_r[RAW_W-1:0];
  assign done  = (state_r == SC_DONE);

endmodule

`default_nettype wire

@@ src/touch_point_filter_and_scale.sv @@
// Top level of the touch point filter: probe detection, five-sample trimmed
// mean, rotation and calibration scaling. Uses tpfs_pkg, tpfs_ifs, tpfs_trim_mean, tpfs_axis_scale.
//
//   channel   dir  payload                         beat taken when
//   in_chan   in   x_word[16], y_word[16]          valid & ready
//   out_chan  out  touched, pixel_x[12], pixel_y[12]  valid & ready
//   cfg_chan  in   index[3], data[12]              valid & ready (ready tied high)
//
// Idle, probe and sample beats are taken one per cycle, idle and probe beats only
// while the output slot is free; a no-touch result is registered in the cycle after its beat.
// After the closing sample the result passes the bit-serial trimmed-mean divider,
// then the shift-add multiplier and the restoring divider of the calibration
// scaler, plus setup and handoff. No new pair is taken while these run.
// A stalled result holds its register.
// Reset (rst_n low, synchronous) returns to idle and loads default registers.
`default_nettype none

module touch_point_filter_and_scale #(
  parameter int SAMPLE_COUNT = 5
) (
  input  logic       clk,
  input  logic       rst_n,
  tpfs_in_if.sink    in_chan,
  tpfs_out_if.source out_chan,
  tpfs_cfg_if.sink   cfg_chan
);
  import tpfs_pkg::*;

  localparam int CNT_W = $clog2(SAMPLE_COUNT);
  localparam logic [CNT_W-1:0] LAST_SAMPLE = CNT_W'(SAMPLE_COUNT - 1);

  typedef enum logic [3:0] {
    ST_IDLE    = 4'b0001,
    ST_COLLECT = 4'b0010,
    ST_MEAN    = 4'b0100,
    ST_SCALE   = 4'b1000
  } state_t;

  state_t           state_r, state_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;

  logic [ROT_W-1:0] rotation_r;
  logic [RAW_W-1:0] screen_width_r;
  logic [RAW_W-1:0] screen_height_r;
  logic [RAW_W-1:0] x_cal_min_r;
  logic [RAW_W-1:0] x_cal_max_r;
  logic [RAW_W-1:0] y_cal_min_r;
  logic [RAW_W-1:0] y_cal_max_r;

  logic             out_valid_r;
  logic             touched_r;
  logic [RAW_W-1:0] pixel_x_r;
  logic [RAW_W-1:0] pixel_y_r;

  logic             in_fire;
  logic             out_free;
  logic [RAW_W-1:0] raw_x;
  logic [RAW_W-1:0] raw_y;
  logic             probe_ok;
  tm_ctl_t          tm_ctl;
  logic [RAW_W-1:0] mean_x;
  logic [RAW_W-1:0] mean_y;
  logic             mean_x_done;
  logic             mean_y_done;
  logic [RAW_W-1:0] rot_x;
  logic [RAW_W-1:0] rot_y;
  logic [RAW_W-1:0] scl_in_x;
  logic [RAW_W-1:0] scl_in_y;
  logic             scale_start;
  logic [RAW_W-1:0] pix_x;
  logic [RAW_W-1:0] pix_y;
  logic             scale_x_done;
  logic             scale_y_done;
  logic             load_idle;
  logic             load_touch;

  // Register writes
  assign cfg_chan.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rotation_r      <= ROTATION_RST;
      screen_width_r  <= WIDTH_RST;
      screen_height_r <= HEIGHT_RST;
      x_cal_min_r     <= X_MIN_RST;
      x_cal_max_r     <= X_MAX_RST;
      y_cal_min_r     <= Y_MIN_RST;
      y_cal_max_r     <= Y_MAX_RST;
    end else if (cfg_chan.valid) begin
      case (cfg_reg_t'(cfg_chan.index))
        REG_ROTATION:      rotation_r      <= cfg_chan.data[ROT_W-1:0];
        REG_SCREEN_WIDTH:  screen_width_r  <= cfg_chan.data[RAW_W-1:0];
        REG_SCREEN_HEIGHT: screen_height_r <= cfg_chan.data[RAW_W-1:0];
        REG_X_CAL_MIN:     x_cal_min_r     <= cfg_chan.data[RAW_W-1:0];
        REG_X_CAL_MAX:     x_cal_max_r     <= cfg_chan.data[RAW_W-1:0];
        REG_Y_CAL_MIN:     y_cal_min_r     <= cfg_chan.data[RAW_W-1:0];
        REG_Y_CAL_MAX:     y_cal_max_r     <= cfg_chan.data[RAW_W-1:0];
        default: ;
      endcase
    end
  end

  // Raw 12-bit reading: drop three low bits, out-of-range words read as zero
  assign raw_x = in_chan.x_word[WORD_W-1] ? '0 : in_chan.x_word[WORD_W-2:WORD_W-1-RAW_W];
  assign raw_y = in_chan.y_word[WORD_W-1] ? '0 : in_chan.y_word[WORD_W-2:WORD_W-1-RAW_W];
  assign probe_ok = (raw_x != '0) && (raw_y != '0);

  // Handshake
  assign out_free      = !out_valid_r || out_chan.ready;
  assign in_chan.ready = (state_r == ST_COLLECT) || ((state_r == ST_IDLE) && out_free);
  assign in_fire       = in_chan.valid && in_chan.ready;

  assign tm_ctl.valid = in_fire && (state_r == ST_COLLECT);
  assign tm_ctl.first = (cnt_r == '0);
  assign tm_ctl.last  = (cnt_r == LAST_SAMPLE);

  // Sequencer
  always_comb begin
    state_nxt   = state_r;
    cnt_nxt     = cnt_r;
    load_idle   = 1'b0;
    load_touch  = 1'b0;
    scale_start = 1'b0;
    case (state_r)
      ST_IDLE: begin
        if (in_fire) begin
          if (probe_ok) begin
            state_nxt = ST_COLLECT;
            cnt_nxt   = '0;
          end else begin
            load_idle = 1'b1;
          end
        end
      end
      ST_COLLECT: begin
        if (in_fire) begin
          if (cnt_r == LAST_SAMPLE) begin
            state_nxt = ST_MEAN;
          end else begin
            cnt_nxt = cnt_r + CNT_W'(1);
          end
        end
      end
      ST_MEAN: begin
        if (mean_x_done && mean_y_done) begin
          scale_start = 1'b1;
          state_nxt   = ST_SCALE;
        end
      end
      ST_SCALE: begin
        if (scale_x_done && scale_y_done && out_free) begin
          load_touch = 1'b1;
          state_nxt  = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

  // Per-axis trimmed mean
  tpfs_trim_mean #(
    .SAMPLE_COUNT (SAMPLE_COUNT)
  ) u_mean_x (
    .clk    (clk),
    .rst_n  (rst_n),
    .ctl    (tm_ctl),
    .sample (raw_x),
    .mean   (mean_x),
    .done   (mean_x_done)
  );

  tpfs_trim_mean #(
    .SAMPLE_COUNT (SAMPLE_COUNT)
  ) u_mean_y (
    .clk    (clk),
    .rst_n  (rst_n),
    .ctl    (tm_ctl),
    .sample (raw_y),
    .mean   (mean_y),
    .done   (mean_y_done)
  );

  // Orientation: swap and mirror the axes
  always_comb begin
    case (rot_t'(rotation_r))
      ROT_FLIP_BOTH: begin
        rot_x = RAW_MAX - mean_x;
        rot_y = RAW_MAX - mean_y;
      end
      ROT_SWAP_FLIP_X: begin
        rot_x = RAW_MAX - mean_y;
        rot_y = mean_x;
      end
      ROT_NONE: begin
        rot_x = mean_x;
        rot_y = mean_y;
      end
      ROT_SWAP_FLIP_Y: begin
        rot_x = mean_y;
        rot_y = RAW_MAX - mean_x;
      end
      default: begin
        rot_x = mean_x;
        rot_y = mean_y;
      end
    endcase
  end

  // Full-scale reading after rotation counts as no reading
  assign scl_in_x = (rot_x == RAW_MAX) ? '0 : rot_x;
  assign scl_in_y = (rot_y == RAW_MAX) ? '0 : rot_y;

  // Per-axis calibration scaling
  tpfs_axis_scale u_scale_x (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (scale_start),
    .raw    (scl_in_x),
    .size   (screen_width_r),
    .cal_lo (x_cal_min_r),
    .cal_hi (x_cal_max_r),
    .pixel  (pix_x),
    .done   (scale_x_done)
  );

  tpfs_axis_scale u_scale_y (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (scale_start),
    .raw    (scl_in_y),
    .size   (screen_height_r),
    .cal_lo (y_cal_min_r),
    .cal_hi (y_cal_max_r),
    .pixel  (pix_y),
    .done   (scale_y_done)
  );

  // Output register: hold the beat until taken
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (load_idle || load_touch) begin
      out_valid_r <= 1'b1;
    end else if (out_chan.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_idle) begin
      touched_r <= 1'b0;
      pixel_x_r <= '0;
      pixel_y_r <= '0;
    end else if (load_touch) begin
      touched_r <= 1'b1;
      pixel_x_r <= pix_x;
      pixel_y_r <= pix_y;
    end
  end

  assign out_chan.valid   = out_valid_r;
  assign out_chan.touched = touched_r;
  assign out_chan.pixel_x = pixel_x_r;
  assign out_chan.pixel_y = pixel_y_r;

endmodule

`default_nettype wire

@@ src/tpfs_checker.sv @@
// Port-level checks of the touch point filter, bound to its top level.
// Depends on tpfs_pkg and touch_point_filter_and_scale_defines.svh.
`default_nettype none
`include "touch_point_filter_and_scale_defines.svh"

module tpfs_checker (
  input wire logic                       clk,
  input wire logic                       rst_n,
  input wire logic                       in_valid,
  input wire logic                       in_ready,
  input wire logic                       out_valid,
  input wire logic                       out_ready,
  input wire logic                       out_touched,
  input wire logic [tpfs_pkg::RAW_W-1:0] out_pixel_x,
  input wire logic [tpfs_pkg::RAW_W-1:0] out_pixel_y
);

  // A stalled result beat keeps its valid and payload
  `TPFS_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid && $stable(out_touched) && $stable(out_pixel_x) && $stable(out_pixel_y), "result beat changed while stalled")

  // A no-touch beat carries zero coordinates
  `TPFS_ASSERT_SAME(a_no_touch_zero, clk, rst_n, out_valid && !out_touched, (out_pixel_x == '0) && (out_pixel_y == '0), "no-touch beat with nonzero pixels")

  // A fresh touch beat never follows an input beat in the next cycle
  `TPFS_ASSERT_NEXT(a_touch_latency, clk, rst_n, in_valid && in_ready, !(out_valid && out_touched && (!$past(out_valid) || $past(out_ready))), "touch result too soon after an input beat")

endmodule

bind touch_point_filter_and_scale tpfs_checker u_tpfs_checker (
  .clk         (clk),
  .rst_n       (rst_n),
  .in_valid    (in_chan.valid),
  .in_ready    (in_chan.ready),
  .out_valid   (out_chan.valid),
  .out_ready   (out_chan.ready),
  .out_touched (out_chan.touched),
  .out_pixel_x (out_chan.pixel_x),
  .out_pixel_y (out_chan.pixel_y)
);

`default_nettype wire

@@ sim/testbench.sv @@
// Self-checking testbench for touch_point_filter_and_scale: drives ADC pairs
// and register writes, predicts every touch point and compares each result beat.
// Depends on tpfs_pkg and the tpfs_in_if, tpfs_out_if, tpfs_cfg_if interfaces.

module testbench;
  import tpfs_pkg::*;

  localparam int SAMPLES       = 5;
  localparam int SETTLE_CYCLES = 80;    // above the mean and scaling run of the block
  localparam int QUIET_LIMIT   = 3000;  // cycles with no beat on any channel
  localparam int GAP_PERCENT   = 18;

  typedef struct packed {
    logic             touched;
    logic [RAW_W-1:0] px;
    logic [RAW_W-1:0] py;
  } touch_point_t;

  logic clk;
  logic rst_n;

  tpfs_in_if  in_bus();
  tpfs_out_if out_bus();
  tpfs_cfg_if cfg_bus();

  touch_point_filter_and_scale #(
    .SAMPLE_COUNT(SAMPLES)
  ) DUT (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_bus),
    .out_chan (out_bus),
    .cfg_chan (cfg_bus)
  );

  // Predictor state: filter stage, accumulators and the screen settings
  int               seq_stage;
  logic [SUM_W-1:0] acc_x, acc_y;
  logic [RAW_W-1:0] lo_x, hi_x, lo_y, hi_y;
  rot_t             orient;
  logic [RAW_W-1:0] span_w, span_h, xcal_lo, xcal_hi, ycal_lo, ycal_hi;

  touch_point_t expected_points[$];
  int           error_count;
  int           results_seen;
  int           pairs_sent;
  int           quiet_cycles;
  bit           in_gaps_on;
  bit           out_stalls_on;

  // Free-running clock
  initial clk = 1'b0;
  always #1 clk = ~clk;

  task automatic report_mismatch(input string msg);
    $display("mismatch at result %0d: %s", results_seen, msg);
    error_count++;
  endtask

  // Drop the three low bits; anything past 12 bits reads as no contact
  function automatic logic [RAW_W-1:0] raw_from_word(input logic [WORD_W-1:0] w);
    return w[15] ? '0 : w[14:3];
  endfunction

  function automatic logic [WORD_W-1:0] word_of(input logic [RAW_W-1:0] raw);
    return {1'b0, raw, 3'($urandom_range(0, 7))};
  endfunction

  // Map a rotated raw value onto pixels; out-of-range or flat spans give 0
  function automatic logic [RAW_W-1:0] scale_to_pixels(input int raw,
      input logic [RAW_W-1:0] size, input logic [RAW_W-1:0] lo,
      input logic [RAW_W-1:0] hi);
    longint num, den, an, ad, q;
    bit     neg;
    num = longint'(size) * (longint'(raw) - longint'(lo));
    den = longint'(hi) - longint'(lo);
    if (den == 0) return '0;
    neg = ((num < 0) != (den < 0)) && (num != 0);
    an  = (num < 0) ? -num : num;
    ad  = (den < 0) ? -den : den;
    q   = an / ad;
    if (neg && q != 0) return '0;
    if (q > longint'(size)) return '0;
    return q[RAW_W-1:0];
  endfunction

  // Advance the filter by one accepted pair and queue any result it yields
  task automatic predict_touch_point(input logic [WORD_W-1:0] xw,
      input logic [WORD_W-1:0] yw);
    logic [RAW_W-1:0] x, y;
    int               mx, my, rx, ry;
    touch_point_t     pt;
    x = raw_from_word(xw);
    y = raw_from_word(yw);
    if (seq_stage == 0) begin
      if (x == 0 || y == 0) begin
        pt = '0;
        expected_points.push_back(pt);
      end else begin
        seq_stage = 1;
      end
      return;
    end
    if (seq_stage == 1) begin
      acc_x = SUM_W'(x);
      acc_y = SUM_W'(y);
      lo_x = x; hi_x = x; lo_y = y; hi_y = y;
    end else begin
      acc_x = acc_x + SUM_W'(x);
      acc_y = acc_y + SUM_W'(y);
      if (x < lo_x) lo_x = x;
      if (x > hi_x) hi_x = x;
      if (y < lo_y) lo_y = y;
      if (y > hi_y) hi_y = y;
    end
    if (seq_stage < SAMPLES) begin
      seq_stage++;
      return;
    end
    seq_stage = 0;
    mx = (int'(acc_x) - int'(hi_x) - int'(lo_x)) / (SAMPLES - 2);
    my = (int'(acc_y) - int'(hi_y) - int'(lo_y)) / (SAMPLES - 2);
    case (orient)
      ROT_FLIP_BOTH: begin
        rx = int'(RAW_MAX) - mx; ry = int'(RAW_MAX) - my;
      end
      ROT_SWAP_FLIP_X: begin
        rx = int'(RAW_MAX) - my; ry = mx;
      end
      ROT_NONE: begin
        rx = mx; ry = my;
      end
      default: begin
        rx = my; ry = int'(RAW_MAX) - mx;
      end
    endcase
    // Full scale after rotation counts as no reading
    if (rx > int'(RAW_MAX) - 1) rx = 0;
    if (ry > int'(RAW_MAX) - 1) ry = 0;
    pt.touched = 1'b1;
    pt.px = scale_to_pixels(rx, span_w, xcal_lo, xcal_hi);
    pt.py = scale_to_pixels(ry, span_h, ycal_lo, ycal_hi);
    expected_points.push_back(pt);
  endtask

  // Send one ADC pair; returns just after the edge that takes the beat
  task automatic push_adc_pair(input logic [WORD_W-1:0] xw, input logic [WORD_W-1:0] yw);
    while (in_gaps_on && $urandom_range(99) < GAP_PERCENT) begin
      @(negedge clk);
      in_bus.valid <= 1'b0;
      @(posedge clk);
    end
    @(negedge clk);
    in_bus.valid  <= 1'b1;
    in_bus.x_word <= xw;
    in_bus.y_word <= yw;
    @(posedge clk);
    while (!in_bus.ready) @(posedge clk);
    predict_touch_point(xw, yw);
    pairs_sent++;
  endtask

  // Hold off the sender until every queued result has come back
  task automatic drain_results;
    @(negedge clk);
    in_bus.valid <= 1'b0;
    while (expected_points.size() != 0) @(posedge clk);
  endtask

  // Drain, then let the block run out its scaling pipeline
  task automatic settle_block;
    drain_results();
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic cfg_write(input cfg_reg_t idx, input logic [CFG_DATA_W-1:0] value);
    @(negedge clk);
    cfg_bus.valid <= 1'b1;
    cfg_bus.index <= idx;
    cfg_bus.data  <= value;
    @(posedge clk);
    while (!cfg_bus.ready) @(posedge clk);
    case (idx)
      REG_ROTATION:      orient  = rot_t'(value[ROT_W-1:0]);
      REG_SCREEN_WIDTH:  span_w  = value;
      REG_SCREEN_HEIGHT: span_h  = value;
      REG_X_CAL_MIN:     xcal_lo = value;
      REG_X_CAL_MAX:     xcal_hi = value;
      REG_Y_CAL_MIN:     ycal_lo = value;
      REG_Y_CAL_MAX:     ycal_hi = value;
      default: ;
    endcase
    @(negedge clk);
    cfg_bus.valid <= 1'b0;
  endtask

  // Write all seven registers; junk in the unused rotation bits
  task automatic program_screen(input rot_t rot, input logic [RAW_W-1:0] w,
      input logic [RAW_W-1:0] h, input logic [RAW_W-1:0] xl, input logic [RAW_W-1:0] xh,
      input logic [RAW_W-1:0] yl, input logic [RAW_W-1:0] yh);
    settle_block();
    cfg_write(REG_ROTATION, {10'($urandom_range(0, 1023)), rot});
    cfg_write(REG_SCREEN_WIDTH, w);
    cfg_write(REG_SCREEN_HEIGHT, h);
    cfg_write(REG_X_CAL_MIN, xl);
    cfg_write(REG_X_CAL_MAX, xh);
    cfg_write(REG_Y_CAL_MIN, yl);
    cfg_write(REG_Y_CAL_MAX, yh);
  endtask

  function automatic logic [RAW_W-1:0] jitter_around(input int c);
    int v;
    v = c + $urandom_range(0, 80) - 40;
    if (v < 0) v = 0;
    if (v > int'(RAW_MAX)) v = int'(RAW_MAX);
    return v[RAW_W-1:0];
  endfunction

  // Probe pair, then a cluster of samples; a few samples are raw noise
  task automatic send_touch_burst;
    int cx, cy;
    cx = $urandom_range(0, 4095);
    cy = $urandom_range(0, 4095);
    push_adc_pair(word_of(12'($urandom_range(1, 4095))),
                  word_of(12'($urandom_range(1, 4095))));
    repeat (SAMPLES) begin
      if ($urandom_range(99) < 5)
        push_adc_pair(16'($urandom), 16'($urandom));
      else
        push_adc_pair(word_of(jitter_around(cx)), word_of(jitter_around(cy)));
    end
  endtask

  // Finish any half-collected set so the filter is back at idle
  task automatic close_open_set;
    while (seq_stage != 0)
      push_adc_pair(word_of(12'($urandom_range(0, 4095))),
                    word_of(12'($urandom_range(0, 4095))));
  endtask

  task automatic run_random_traffic(input int n);
    int start, r;
    start = pairs_sent;
    while (pairs_sent - start < n) begin
      r = $urandom_range(99);
      if (r < 75) begin
        send_touch_burst();
        if ($urandom_range(99) < 4) drain_results();
      end else if (r < 88) begin
        // idle pair with one axis open: no-touch answer when the filter is idle
        if ($urandom_range(1))
          push_adc_pair(16'($urandom) | 16'h8000, 16'($urandom));
        else
          push_adc_pair(16'($urandom), 16'($urandom_range(0, 7)));
      end else begin
        push_adc_pair(16'($urandom), 16'($urandom));
      end
    end
    close_open_set();
  endtask

  // Idle pairs with a missing axis each answer no touch
  task automatic test_no_touch;
    push_adc_pair(16'h0000, 16'h1234);
    push_adc_pair(16'h4000, 16'h0007);
    push_adc_pair(16'hFFFF, 16'h7FFF);
    push_adc_pair(16'h8000, 16'h8000);
    push_adc_pair(16'h0007, 16'hFFF8);
  endtask

  // One set at reset settings with field extremes and zero samples
  task automatic test_trim_extremes;
    push_adc_pair(16'h7FFF, 16'h0008);
    push_adc_pair(16'h0008, 16'h7FFF);
    push_adc_pair(16'hFFFF, 16'h0000);
    push_adc_pair(16'h7FF8, 16'h7FF8);
    push_adc_pair(16'h3E80, 16'h2000);
    push_adc_pair(16'h1000, 16'h5555);
  endtask

  // Full-scale mean without rotation folds to zero, then falls below cal min
  task automatic test_rotated_limit;
    program_screen(ROT_NONE, WIDTH_RST, HEIGHT_RST, X_MIN_RST, X_MAX_RST,
                   Y_MIN_RST, Y_MAX_RST);
    repeat (SAMPLES + 1) push_adc_pair(16'h7FFF, 16'h7FFF);
  endtask

  // Flat X calibration and inverted Y calibration
  task automatic test_calibration_corners;
    program_screen(ROT_NONE, 12'd4095, 12'd100, 12'd2048, 12'd2048, 12'd3000, 12'd1000);
    push_adc_pair(word_of(12'd2000), word_of(12'd2000));
    for (int i = 0; i < SAMPLES; i++)
      push_adc_pair(word_of(12'(1990 + 5 * i)), word_of(12'(1990 + 5 * i)));
  endtask

  task automatic test_random_settings;
    for (int p = 0; p < 6; p++) begin
      case (p)
        0: program_screen(ROT_FLIP_BOTH, 12'd4095, 12'd4095, 12'd0, 12'd4095, 12'd0, 12'd4095);
        1: program_screen(ROT_SWAP_FLIP_X, 12'd1, 12'd1, 12'd4095, 12'd0, 12'd4095, 12'd0);
        2: program_screen(ROT_NONE, 12'($urandom_range(1, 4095)), 12'($urandom_range(1, 4095)),
                          12'd1777, 12'd1777, 12'($urandom_range(0, 1200)),
                          12'($urandom_range(2800, 4095)));
        3: program_screen(ROT_SWAP_FLIP_Y, 12'($urandom_range(1, 4095)),
                          12'($urandom_range(1, 4095)), 12'($urandom_range(0, 1200)),
                          12'($urandom_range(2800, 4095)), 12'($urandom_range(0, 1200)),
                          12'($urandom_range(2800, 4095)));
        default: program_screen(rot_t'($urandom_range(0, 3)), 12'($urandom_range(1, 4095)),
                          12'($urandom_range(1, 4095)), 12'($urandom), 12'($urandom),
                          12'($urandom), 12'($urandom));
      endcase
      run_random_traffic(90);
    end
  endtask

  // Back-to-back beats on both sides
  task automatic test_steady_flow;
    program_screen(rot_t'($urandom_range(0, 3)), 12'($urandom_range(1, 4095)),
                   12'($urandom_range(1, 4095)), 12'($urandom_range(0, 1200)),
                   12'($urandom_range(2800, 4095)), 12'($urandom_range(0, 1200)),
                   12'($urandom_range(2800, 4095)));
    in_gaps_on    = 1'b0;
    out_stalls_on = 1'b0;
    run_random_traffic(110);
    in_gaps_on    = 1'b1;
    out_stalls_on = 1'b1;
  endtask

  // Result side: random backpressure, changed on the falling edge
  initial begin
    out_bus.ready = 1'b0;
    forever begin
      @(negedge clk);
      out_bus.ready <= !out_stalls_on || ($urandom_range(99) >= GAP_PERCENT);
    end
  end

  // Compare each result beat with the oldest prediction
  always @(posedge clk) begin
    touch_point_t want;
    if (rst_n && out_bus.valid && out_bus.ready) begin
      if (expected_points.size() == 0) begin
        report_mismatch($sformatf("unexpected beat touched=%0d x=%0d y=%0d",
                                  out_bus.touched, out_bus.pixel_x, out_bus.pixel_y));
      end else begin
        want = expected_points.pop_front();
        if (out_bus.touched !== want.touched)
          report_mismatch($sformatf("touched got %0d want %0d", out_bus.touched, want.touched));
        if (out_bus.pixel_x !== want.px)
          report_mismatch($sformatf("pixel_x got %0d want %0d", out_bus.pixel_x, want.px));
        if (out_bus.pixel_y !== want.py)
          report_mismatch($sformatf("pixel_y got %0d want %0d", out_bus.pixel_y, want.py));
      end
      results_seen++;
    end
  end

  // Watchdog: end the run when no channel moves for too long
  always @(posedge clk) begin
    if ((in_bus.valid && in_bus.ready) || (out_bus.valid && out_bus.ready) ||
        (cfg_bus.valid && cfg_bus.ready))
      quiet_cycles = 0;
    else
      quiet_cycles++;
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("watchdog: no beat for %0d cycles", QUIET_LIMIT);
      $display("testbench: done, errors");
      $finish;
    end
  end

  initial begin
    rst_n          = 1'b0;
    in_bus.valid   = 1'b0;
    in_bus.x_word  = '0;
    in_bus.y_word  = '0;
    cfg_bus.valid  = 1'b0;
    cfg_bus.index  = REG_ROTATION;
    cfg_bus.data   = '0;
    in_gaps_on     = 1'b1;
    out_stalls_on  = 1'b1;
    error_count    = 0;
    results_seen   = 0;
    pairs_sent     = 0;
    quiet_cycles   = 0;
    seq_stage      = 0;
    acc_x = '0; acc_y = '0;
    lo_x = '0; hi_x = '0; lo_y = '0; hi_y = '0;
    orient  = rot_t'(ROTATION_RST);
    span_w  = WIDTH_RST;
    span_h  = HEIGHT_RST;
    xcal_lo = X_MIN_RST;
    xcal_hi = X_MAX_RST;
    ycal_lo = Y_MIN_RST;
    ycal_hi = Y_MAX_RST;

    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_no_touch();
    test_trim_extremes();
    test_rotated_limit();
    test_calibration_corners();
    test_random_settings();
    test_steady_flow();

    settle_block();
    if (error_count == 0)
      $display("testbench: done, clean");
    else
      $display("testbench: done, errors");
    $finish;
  end

endmodule
